// ----- src/sra_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants of the shelf rectangle allocator
// Holds the atlas geometry, the command and status codes, the transaction
// payloads and the token that walks the row of shelf cells.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int ATLAS_SIZE  = 1024;
    localparam int MAX_SHELVES = 256;
    localparam int CELL_GAP    = 1;

    // Field widths are fixed by the transaction format
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int SUM_W   = DIM_W + 1;

    localparam logic [SUM_W-1:0] ATLAS_S = SUM_W'(ATLAS_SIZE);
    localparam logic [SUM_W-1:0] GAP_S   = SUM_W'(CELL_GAP);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_REJECT  = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        cmd_t             command;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [COORD_W-1:0] place_x;
        logic [COORD_W-1:0] place_y;
    } out_t;

    // Request token handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               done;
        logic               set_full;
        status_t            status;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [DIM_W-1:0]   next_y;
    } tok_t;

endpackage
`default_nettype wire

// ----- src/sra_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sra_cell: one shelf slot
// Holds the top row, height and fill of one shelf. A passing request token
// is placed on this shelf if it fits, opens the shelf if the slot is unused,
// or carries on with the bottom edge of this shelf.
// ----------------------------------------------------------------------------
module sra_cell
    import sra_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic clear,
    input  wire tok_t tok_in,
    output tok_t      tok_out
);

    logic               valid_reg, valid_next;
    logic [COORD_W-1:0] top_reg, top_next;
    logic [DIM_W-1:0]   tall_reg, tall_next;
    logic [DIM_W-1:0]   fill_reg, fill_next;
    tok_t               tok_reg, tok_next;

    logic [SUM_W-1:0] fill_sum;
    logic [SUM_W-1:0] bottom_sum;
    logic [SUM_W-1:0] new_bottom;

    assign fill_sum   = SUM_W'(fill_reg) + SUM_W'(tok_in.w);
    assign bottom_sum = SUM_W'(top_reg) + SUM_W'(tall_reg) + GAP_S;
    assign new_bottom = SUM_W'(tok_in.next_y) + SUM_W'(tok_in.h);

    always_comb begin
        valid_next = valid_reg;
        top_next   = top_reg;
        tall_next  = tall_reg;
        fill_next  = fill_reg;
        tok_next   = tok_in;
        if (clear) begin
            valid_next = 1'b0;
        end else if (tok_in.active && !tok_in.done) begin
            if (valid_reg) begin
                if (tall_reg >= tok_in.h && fill_sum <= ATLAS_S) begin
                    fill_next       = DIM_W'(fill_sum + GAP_S);
                    tok_next.done   = 1'b1;
                    tok_next.status = ST_PLACED;
                    tok_next.x      = fill_reg[COORD_W-1:0];
                    tok_next.y      = top_reg;
                end else begin
                    tok_next.next_y = DIM_W'(bottom_sum);
                end
            end else begin
                // first unused slot: open a new shelf here if it fits
                tok_next.done = 1'b1;
                tok_next.x    = '0;
                tok_next.y    = '0;
                if (SUM_W'(tok_in.w) > ATLAS_S) begin
                    tok_next.status = ST_REJECT;
                end else if (new_bottom > ATLAS_S) begin
                    tok_next.status   = ST_REJECT;
                    tok_next.set_full = 1'b1;
                end else begin
                    valid_next      = 1'b1;
                    top_next        = tok_in.next_y[COORD_W-1:0];
                    tall_next       = tok_in.h;
                    fill_next       = DIM_W'(SUM_W'(tok_in.w) + GAP_S);
                    tok_next.status = ST_PLACED;
                    tok_next.y      = tok_in.next_y[COORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg  <= top_next;
        tall_reg <= tall_next;
        fill_reg <= fill_next;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ----- src/sra_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sra_ctrl: request sequencer of the shelf rectangle allocator
// Takes input transactions, answers clear, empty and full requests at once,
// launches allocation tokens into the shelf row, collects them at the tail
// and drives the result register.
// ----------------------------------------------------------------------------
module sra_ctrl
    import sra_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data,
    output logic      clear,
    output tok_t      inject,
    input  wire tok_t tail
);

    ctrl_state_t state_reg, state_next;
    logic        full_reg, full_next;
    out_t        res_reg, res_next;
    tok_t        inject_reg, inject_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    always_comb begin
        state_next   = state_reg;
        full_next    = full_reg;
        res_next     = res_reg;
        inject_next  = inject_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        clear        = 1'b0;
        s_ready      = (state_reg == S_IDLE);

        inject_next.active = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next = '{status: ST_REJECT, place_x: '0, place_y: '0};
                    state_next = S_DONE;
                    case (s_data.command)
                        CMD_CLEAR: begin
                            clear           = 1'b1;
                            full_next       = 1'b0;
                            res_next.status = ST_CLEARED;
                        end
                        default: begin
                            if (full_reg) begin
                                res_next.status = ST_REJECT;
                            end else if (s_data.rect_width == '0 ||
                                         s_data.rect_height == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                inject_next = '{active: 1'b1, done: 1'b0, set_full: 1'b0,
                                                status: ST_REJECT, x: '0, y: '0,
                                                w: s_data.rect_width,
                                                h: s_data.rect_height,
                                                next_y: '0};
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (tail.active) begin
                    state_next = S_DONE;
                    if (tail.done) begin
                        res_next = '{status: tail.status, place_x: tail.x, place_y: tail.y};
                        if (tail.set_full) begin
                            full_next = 1'b1;
                        end
                    end else begin
                        // every slot in use: full unless the width alone fails
                        res_next = '{status: ST_REJECT, place_x: '0, place_y: '0};
                        if (SUM_W'(tail.w) <= ATLAS_S) begin
                            full_next = 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            inject_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            full_reg    <= full_next;
            m_valid_reg <= m_valid_next;
            inject_reg  <= inject_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign inject  = inject_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- src/shelf_rect_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shelf_rect_allocator: first-fit shelf packing for a square texture atlas
// Input transactions (s_valid/s_ready, s_data) carry a command and a
// rectangle size; each produces exactly one result transaction (m_valid/
// m_ready, m_data) with a status and, when placed, the top-left corner.
// The shelves live in a row of MAX_SHELVES cells. An allocation token enters
// cell 0 and moves one cell per cycle; the first shelf with room takes it,
// or the first unused cell opens a new shelf. An allocation's result is
// registered in the sequencer once the token leaves the last cell; a clear,
// empty or rejected-while-full request goes straight to the result register.
// With the output free, the result then moves to the output register and
// the sequencer returns to idle to take the next request.
// One request is handled at a time; s_ready is high while the sequencer is
// idle, so a new request can be taken while the last result still waits in
// the output register.
// Reset (aresetn low, synchronous) empties all shelves, drops the full flag
// and the output valid. When m_ready is low the result is held and the next
// request waits in its final step until the output register frees up.
// ----------------------------------------------------------------------------
module shelf_rect_allocator
    import sra_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic clear;
    tok_t chain [MAX_SHELVES+1];

    sra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .clear   (clear),
        .inject  (chain[0]),
        .tail    (chain[MAX_SHELVES])
    );

    for (genvar i = 0; i < MAX_SHELVES; i++) begin : g_cell
        sra_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (clear),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

endmodule
`default_nettype wire
